// ----- design/swept_aabb_collision_defines.svh -----
// Assertion macros used by the block's top-level RTL.
`ifndef SWEPT_AABB_COLLISION_DEFINES_SVH
`define SWEPT_AABB_COLLISION_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/sac_pkg.sv -----
`default_nettype none
package sac_pkg;
  localparam int COORD_BITS_DEF     = 16;
  localparam int MOVE_FRAC_BITS_DEF = 8;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int MOVE_BITS          = 24;

  localparam logic [1:0] NORM_NONE = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  // per-beat flags carried alongside the dividers
  typedef struct packed {
    logic rej;      // broad-phase miss or no motion
    logic dx_zero;
    logic dy_zero;
    logic dx_pos;
    logic dy_pos;
  } sb_t;
endpackage
`default_nettype wire

// ----- design/sac_front.sv -----
`default_nettype none
module sac_front
  import sac_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int MOVE_FRAC_BITS = MOVE_FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic signed [COORD_BITS-1:0]            mover_left,
  input  wire logic signed [COORD_BITS-1:0]            mover_top,
  input  wire logic signed [COORD_BITS-1:0]            mover_right,
  input  wire logic signed [COORD_BITS-1:0]            mover_bottom,
  input  wire logic signed [MOVE_BITS-1:0]             move_x,
  input  wire logic signed [MOVE_BITS-1:0]             move_y,
  input  wire logic signed [COORD_BITS-1:0]            still_left,
  input  wire logic signed [COORD_BITS-1:0]            still_top,
  input  wire logic signed [COORD_BITS-1:0]            still_right,
  input  wire logic signed [COORD_BITS-1:0]            still_bottom,
  output sb_t                                          sb_r,
  output logic [COORD_BITS+MOVE_FRAC_BITS:0]           an_xe_r,
  output logic [COORD_BITS+MOVE_FRAC_BITS:0]           an_xx_r,
  output logic [COORD_BITS+MOVE_FRAC_BITS:0]           an_ye_r,
  output logic [COORD_BITS+MOVE_FRAC_BITS:0]           an_yx_r,
  output logic                                         neg_xe_r,
  output logic                                         neg_xx_r,
  output logic                                         neg_ye_r,
  output logic                                         neg_yx_r,
  output logic [MOVE_BITS-1:0]                         ad_x_r,
  output logic [MOVE_BITS-1:0]                         ad_y_r
);
  localparam int AN_W = COORD_BITS + 1 + MOVE_FRAC_BITS;
  localparam int SW   = ((COORD_BITS + MOVE_FRAC_BITS > MOVE_BITS) ?
                         COORD_BITS + MOVE_FRAC_BITS : MOVE_BITS) + 2;
  localparam int NW   = COORD_BITS + 1;
  localparam logic signed [SW-1:0] SZERO = '0;

  logic signed [SW-1:0] mls, mts, mrs, mbs, sls, sts, srs, sbs, dxe, dye;
  logic signed [SW-1:0] bl, bt, br, bb;
  logic                 dx_pos, dy_pos, dx_neg, dy_neg, dx_zero, dy_zero, broad;
  logic signed [NW-1:0] nxa, nxb, nya, nyb, nxe, nxx, nye, nyx;
  logic [NW-1:0]        axe, axx, aye, ayx;

  assign mls = SW'(mover_left)   <<< MOVE_FRAC_BITS;
  assign mts = SW'(mover_top)    <<< MOVE_FRAC_BITS;
  assign mrs = SW'(mover_right)  <<< MOVE_FRAC_BITS;
  assign mbs = SW'(mover_bottom) <<< MOVE_FRAC_BITS;
  assign sls = SW'(still_left)   <<< MOVE_FRAC_BITS;
  assign sts = SW'(still_top)    <<< MOVE_FRAC_BITS;
  assign srs = SW'(still_right)  <<< MOVE_FRAC_BITS;
  assign sbs = SW'(still_bottom) <<< MOVE_FRAC_BITS;
  assign dxe = SW'(move_x);
  assign dye = SW'(move_y);

  assign dx_neg  = move_x[MOVE_BITS-1];
  assign dy_neg  = move_y[MOVE_BITS-1];
  assign dx_zero = (move_x == '0);
  assign dy_zero = (move_y == '0);
  assign dx_pos  = !dx_neg && !dx_zero;
  assign dy_pos  = !dy_neg && !dy_zero;

  // swept box
  assign bl = mls + (dx_pos ? SZERO : dxe);
  assign br = mrs + (dx_pos ? dxe : SZERO);
  assign bt = mts + (dy_pos ? SZERO : dye);
  assign bb = mbs + (dy_pos ? dye : SZERO);
  assign broad = (br < sls) || (bl > srs) || (bb < sts) || (bt > sbs);

  assign nxa = NW'(still_left)  - NW'(mover_right);
  assign nxb = NW'(still_right) - NW'(mover_left);
  assign nya = NW'(still_top)    - NW'(mover_bottom);
  assign nyb = NW'(still_bottom) - NW'(mover_top);
  assign nxe = dx_pos ? nxa : nxb;
  assign nxx = dx_pos ? nxb : nxa;
  assign nye = dy_pos ? nya : nyb;
  assign nyx = dy_pos ? nyb : nya;

  assign axe = nxe[NW-1] ? NW'(-nxe) : NW'(nxe);
  assign axx = nxx[NW-1] ? NW'(-nxx) : NW'(nxx);
  assign aye = nye[NW-1] ? NW'(-nye) : NW'(nye);
  assign ayx = nyx[NW-1] ? NW'(-nyx) : NW'(nyx);

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r.rej     <= broad || (dx_zero && dy_zero);
      sb_r.dx_zero <= dx_zero;
      sb_r.dy_zero <= dy_zero;
      sb_r.dx_pos  <= dx_pos;
      sb_r.dy_pos  <= dy_pos;
      an_xe_r  <= AN_W'(axe) << MOVE_FRAC_BITS;
      an_xx_r  <= AN_W'(axx) << MOVE_FRAC_BITS;
      an_ye_r  <= AN_W'(aye) << MOVE_FRAC_BITS;
      an_yx_r  <= AN_W'(ayx) << MOVE_FRAC_BITS;
      neg_xe_r <= nxe[NW-1] ^ dx_neg;
      neg_xx_r <= nxx[NW-1] ^ dx_neg;
      neg_ye_r <= nye[NW-1] ^ dy_neg;
      neg_yx_r <= nyx[NW-1] ^ dy_neg;
      ad_x_r   <= dx_neg ? MOVE_BITS'(-move_x) : MOVE_BITS'(move_x);
      ad_y_r   <= dy_neg ? MOVE_BITS'(-move_y) : MOVE_BITS'(move_y);
    end
  end
endmodule
`default_nettype wire

// ----- design/sac_div.sv -----
`default_nettype none
module sac_div
  import sac_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int MOVE_FRAC_BITS = MOVE_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [TIME_FRAC_BITS+3:0]             en,
  input  wire logic [COORD_BITS+MOVE_FRAC_BITS:0]    an,
  input  wire logic [MOVE_BITS-1:0]                  ad,
  input  wire logic                                  neg,
  output logic signed [TIME_FRAC_BITS+4:0]           t_r
);
  localparam int AN_W = COORD_BITS + 1 + MOVE_FRAC_BITS;
  localparam int D_W  = MOVE_BITS + 2;
  localparam int R_W  = ((AN_W > D_W) ? AN_W : D_W) + 1;
  localparam int QB   = TIME_FRAC_BITS + 2;
  localparam int T_W  = TIME_FRAC_BITS + 5;
  localparam logic [QB:0] LIM = {1'b1, {QB{1'b0}}};

  logic [R_W-1:0] r_r   [0:QB];
  logic [D_W-1:0] d_r   [0:QB];
  logic [QB-1:0]  q_r   [0:QB];
  logic           sat_r [0:QB];
  logic           neg_r [0:QB];

  logic [D_W-1:0]        d_in;
  logic [QB:0]           mag_nxt;
  logic signed [T_W-1:0] ms_nxt;

  assign d_in = {ad, 2'b00};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]   <= R_W'(an);
      d_r[0]   <= d_in;
      q_r[0]   <= '0;
      sat_r[0] <= R_W'(an) >= R_W'(d_in);
      neg_r[0] <= neg;
    end
  end

  // one restoring step per stage, divisor held as 4*|d|
  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [R_W-1:0] sh;
    logic           ge;
    assign sh = {r_r[j-1][R_W-2:0], 1'b0};
    assign ge = sh >= R_W'(d_r[j-1]);
    always_ff @(posedge clk) begin
      if (en[j]) begin
        r_r[j]   <= ge ? sh - R_W'(d_r[j-1]) : sh;
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= {q_r[j-1][QB-2:0], ge};
        sat_r[j] <= sat_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  // floor on negative quotients: bump magnitude when inexact
  assign mag_nxt = sat_r[QB] ? LIM :
                   ({1'b0, q_r[QB]} + (QB+1)'(neg_r[QB] && (r_r[QB] != '0)));
  assign ms_nxt  = $signed(T_W'(mag_nxt));

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      t_r <= neg_r[QB] ? -ms_nxt : ms_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/sac_resolve.sv -----
`default_nettype none
module sac_resolve
  import sac_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [1:0]                            en,
  input  sb_t                                        sb,
  input  wire logic signed [TIME_FRAC_BITS+4:0]      txe,
  input  wire logic signed [TIME_FRAC_BITS+4:0]      txx,
  input  wire logic signed [TIME_FRAC_BITS+4:0]      tye,
  input  wire logic signed [TIME_FRAC_BITS+4:0]      tyx,
  output logic                                       hit_r,
  output logic [TIME_FRAC_BITS:0]                    entry_time_r,
  output logic [1:0]                                 normal_x_r,
  output logic [1:0]                                 normal_y_r
);
  localparam int T_W = TIME_FRAC_BITS + 5;
  localparam logic signed [T_W-1:0] INF  = {2'b01, {(TIME_FRAC_BITS+3){1'b0}}};
  localparam logic signed [T_W-1:0] ONE  = {5'b00001, {TIME_FRAC_BITS{1'b0}}};
  localparam logic signed [T_W-1:0] ZERO = '0;

  logic signed [T_W-1:0] xe, xx, ye, yx, tin_nxt, tout_nxt;
  logic signed [T_W-1:0] tin_r, tout_r;
  logic                  rej_r, xwin_r, dx_pos_r, dy_pos_r;
  logic                  xwin, hit_nxt;

  // still axis: enters at minus infinity, leaves at plus infinity
  assign xe = sb.dx_zero ? -INF : txe;
  assign xx = sb.dx_zero ?  INF : txx;
  assign ye = sb.dy_zero ? -INF : tye;
  assign yx = sb.dy_zero ?  INF : tyx;

  assign xwin     = xe > ye;
  assign tin_nxt  = xwin ? xe : ye;
  assign tout_nxt = (xx < yx) ? xx : yx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rej_r    <= sb.rej || ((xe < ZERO) && (ye < ZERO)) || (xe > ONE) || (ye > ONE);
      tin_r    <= tin_nxt;
      tout_r   <= tout_nxt;
      xwin_r   <= xwin;
      dx_pos_r <= sb.dx_pos;
      dy_pos_r <= sb.dy_pos;
    end
  end

  assign hit_nxt = !rej_r && !(tin_r > tout_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit_r        <= hit_nxt;
      entry_time_r <= hit_nxt ? tin_r[TIME_FRAC_BITS:0] : '0;
      normal_x_r   <= (hit_nxt && xwin_r) ? (dx_pos_r ? NORM_NEG : NORM_POS) : NORM_NONE;
      normal_y_r   <= (hit_nxt && !xwin_r) ? (dy_pos_r ? NORM_NEG : NORM_POS) : NORM_NONE;
    end
  end
endmodule
`default_nettype wire

// ----- design/swept_aabb_collision.sv -----
// Four divide pipelines, one quotient bit per stage, sit between front and resolve stages.
// Throughput: one box pair per cycle unless out_tready stalls the output.
// Each stage holds its beat when the stage ahead is full and stalled, so bubbles close up.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
`default_nettype none
`include "swept_aabb_collision_defines.svh"
module swept_aabb_collision
  import sac_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int MOVE_FRAC_BITS = MOVE_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // mover_left, mover_top, mover_right, mover_bottom, move_x, move_y,
  // still_left, still_top, still_right, still_bottom
  input  wire logic [((8*COORD_BITS+2*MOVE_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // hit, entry_time, normal_x, normal_y
  output logic [((TIME_FRAC_BITS+6+7)/8)*8-1:0] out_tdata
);
  localparam int CB     = COORD_BITS;
  localparam int MB     = MOVE_BITS;
  localparam int AN_W   = COORD_BITS + 1 + MOVE_FRAC_BITS;
  localparam int T_W    = TIME_FRAC_BITS + 5;
  localparam int DL     = TIME_FRAC_BITS + 4;   // divider stages
  localparam int L      = DL + 3;               // front + divider + two resolve stages
  localparam int OUT_W  = TIME_FRAC_BITS + 6;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // ---- valid chain and per-stage load enables ----
  // A stage loads when it is empty or the stage ahead loads too.
  logic [L-1:0] v_r, v_nxt, en;

  for (genvar k = 0; k < L; k++) begin : g_en
    if (k == L-1) begin : g_last
      assign en[k] = !v_r[k] || out_tready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < L; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[L-1];

  // ---- front: swept-box reject, distances, magnitudes ----
  sb_t                 sb0;
  logic [AN_W-1:0]     an_xe, an_xx, an_ye, an_yx;
  logic                neg_xe, neg_xx, neg_ye, neg_yx;
  logic [MB-1:0]       ad_x, ad_y;

  sac_front #(
    .COORD_BITS     (COORD_BITS),
    .MOVE_FRAC_BITS (MOVE_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .en           (en[0]),
    .mover_left   (in_tdata[0 +: CB]),
    .mover_top    (in_tdata[CB +: CB]),
    .mover_right  (in_tdata[2*CB +: CB]),
    .mover_bottom (in_tdata[3*CB +: CB]),
    .move_x       (in_tdata[4*CB +: MB]),
    .move_y       (in_tdata[4*CB+MB +: MB]),
    .still_left   (in_tdata[4*CB+2*MB +: CB]),
    .still_top    (in_tdata[5*CB+2*MB +: CB]),
    .still_right  (in_tdata[6*CB+2*MB +: CB]),
    .still_bottom (in_tdata[7*CB+2*MB +: CB]),
    .sb_r         (sb0),
    .an_xe_r      (an_xe),
    .an_xx_r      (an_xx),
    .an_ye_r      (an_ye),
    .an_yx_r      (an_yx),
    .neg_xe_r     (neg_xe),
    .neg_xx_r     (neg_xx),
    .neg_ye_r     (neg_ye),
    .neg_yx_r     (neg_yx),
    .ad_x_r       (ad_x),
    .ad_y_r       (ad_y)
  );

  // ---- four time quotients: x entry/exit, y entry/exit ----
  logic signed [T_W-1:0] txe, txx, tye, tyx;

  sac_div #(.COORD_BITS(COORD_BITS), .MOVE_FRAC_BITS(MOVE_FRAC_BITS),
            .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xe (
    .clk(clk), .en(en[1 +: DL]), .an(an_xe), .ad(ad_x), .neg(neg_xe), .t_r(txe));
  sac_div #(.COORD_BITS(COORD_BITS), .MOVE_FRAC_BITS(MOVE_FRAC_BITS),
            .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xx (
    .clk(clk), .en(en[1 +: DL]), .an(an_xx), .ad(ad_x), .neg(neg_xx), .t_r(txx));
  sac_div #(.COORD_BITS(COORD_BITS), .MOVE_FRAC_BITS(MOVE_FRAC_BITS),
            .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_ye (
    .clk(clk), .en(en[1 +: DL]), .an(an_ye), .ad(ad_y), .neg(neg_ye), .t_r(tye));
  sac_div #(.COORD_BITS(COORD_BITS), .MOVE_FRAC_BITS(MOVE_FRAC_BITS),
            .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_yx (
    .clk(clk), .en(en[1 +: DL]), .an(an_yx), .ad(ad_y), .neg(neg_yx), .t_r(tyx));

  // ---- flags ride alongside the dividers ----
  sb_t sb_r [1:DL];

  for (genvar k = 1; k <= DL; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sb_r[k] <= (k == 1) ? sb0 : sb_r[(k == 1) ? 1 : k-1];
      end
    end
  end

  // ---- resolve: window test, normal, output register ----
  logic                      hit;
  logic [TIME_FRAC_BITS:0]   entry_time;
  logic [1:0]                normal_x, normal_y;

  sac_resolve #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_resolve (
    .clk          (clk),
    .en           (en[L-2 +: 2]),
    .sb           (sb_r[DL]),
    .txe          (txe),
    .txx          (txx),
    .tye          (tye),
    .tyx          (tyx),
    .hit_r        (hit),
    .entry_time_r (entry_time),
    .normal_x_r   (normal_x),
    .normal_y_r   (normal_y)
  );

  assign out_tdata = OUT_TW'({normal_y, normal_x, entry_time, hit});

  // ---- checks ----
  `SAC_ASSERT_IMP(a_miss_clean, clk, rst_n, out_tvalid && !hit, (entry_time == '0) && (normal_x == NORM_NONE) && (normal_y == NORM_NONE), "miss with nonzero payload")
  `SAC_ASSERT_IMP(a_one_normal, clk, rst_n, out_tvalid && hit, (normal_x == NORM_NONE) != (normal_y == NORM_NONE), "hit must carry exactly one normal axis")
  `SAC_ASSERT_IMP(a_entry_range, clk, rst_n, out_tvalid && hit, entry_time <= {1'b1, {TIME_FRAC_BITS{1'b0}}}, "entry time above one frame")
  `SAC_ASSERT_IMP(a_full_stall, clk, rst_n, !in_tready, (&v_r) && !out_tready, "input stalled with a free stage")
  `SAC_ASSERT_NXT(a_accept_lands, clk, rst_n, in_tvalid && in_tready, v_r[0], "accepted beat not captured")
endmodule
`default_nettype wire
